>>> hdl/iprt_pkg.sv
// shared types and constants of the in-flight packet rtt tracker
`default_nettype none
package iprt_pkg;

	// item command codes
	localparam logic CMD_SEND = 1'b0;
	localparam logic CMD_ACK  = 1'b1;

	// result status codes
	localparam logic [2:0] ST_SENT     = 3'd0;
	localparam logic [2:0] ST_DROPPED  = 3'd1;
	localparam logic [2:0] ST_MATCHED  = 3'd2;
	localparam logic [2:0] ST_IGNORED  = 3'd3;
	localparam logic [2:0] ST_DISABLED = 3'd4;

	// work handed from front to back
	typedef enum logic [1:0] {
		OP_PASS,
		OP_WRITE,
		OP_READ
	} op_t;

	typedef struct packed {
		logic        cmd;
		logic [31:0] now_ms;
		logic [31:0] ack_seq;
		logic [31:0] ack_receive_ts;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] seq;
		logic [31:0] rtt_ms;
		logic [31:0] owd_ms;
	} result_t;

	// queue entry without the table slot, whose width follows the depth
	typedef struct packed {
		op_t         op;
		logic [2:0]  status;
		logic [31:0] seq;
		logic [31:0] now_ms;
		logic [31:0] rts_ms;
	} work_t;

endpackage
`default_nettype wire

>>> hdl/inflight_packet_rtt_tracker.sv
// Path: a send, dropped, ignored or disabled result passes the queue and the result
// register before it is poppable, a matched ack the queue, the table read and the result register.
// Rate: one item per cycle for sends and unmatched items while results are popped; after
// a matched ack the back end takes no new item until the registered table read completes.
// Reset: enable set, next sequence and oldest unacked at 1, ring empty, queues empty;
// the send-time table is not cleared.
`default_nettype none
module inflight_packet_rtt_tracker #(
	parameter int TABLE_DEPTH = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic              cfg_data,
	input  wire logic              push,
	output logic                   full,
	input  wire iprt_pkg::item_t   item,
	output logic                   empty,
	input  wire logic              pop,
	output iprt_pkg::result_t      result
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int Q_W   = $bits(iprt_pkg::work_t) + IDX_W;

	logic             q_push;
	logic             q_full;
	logic             q_pop;
	logic             q_empty;
	iprt_pkg::work_t  fe_work;
	logic [IDX_W-1:0] fe_slot;
	iprt_pkg::work_t  be_work;
	logic [IDX_W-1:0] be_slot;
	logic [Q_W-1:0]   q_rd_data;

	// classification and ring pointers
	iprt_front #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.push     (push),
		.full     (full),
		.item     (item),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_work   (fe_work),
		.q_slot   (fe_slot)
	);

	// decoupling queue
	iprt_fifo #(
		.WIDTH(Q_W)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_data({fe_work, fe_slot}),
		.full   (q_full),
		.rd_en  (q_pop),
		.rd_data(q_rd_data),
		.empty  (q_empty)
	);

	assign be_work = q_rd_data[Q_W-1:IDX_W];
	assign be_slot = q_rd_data[IDX_W-1:0];

	// table access and result
	iprt_back #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_empty(q_empty),
		.q_work (be_work),
		.q_slot (be_slot),
		.q_pop  (q_pop),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule
`default_nettype wire

>>> hdl/iprt_front.sv
// front end: accepts items, classifies them and keeps the ring pointers
`default_nettype none
module iprt_front #(
	parameter int TABLE_DEPTH = 256
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic                 cfg_data,
	input  wire logic                 push,
	output logic                      full,
	input  wire iprt_pkg::item_t      item,
	input  wire logic                 q_full,
	output logic                      q_push,
	output iprt_pkg::work_t           q_work,
	output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] q_slot
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
	localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(TABLE_DEPTH);

	logic             enable_q;
	logic [31:0]      next_seq_q;
	logic [31:0]      oldest_q;
	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;

	logic             accept;
	logic [31:0]      ack_ofs;
	logic             hit;
	logic             ring_full;
	logic [CNT_W-1:0] step;
	logic [SUM_W-1:0] wr_sum, rd_sum, nh_sum;
	logic [SUM_W-1:0] wr_mod, rd_mod, nh_mod;

	assign cfg_ready = 1'b1;
	assign accept    = push && !q_full;
	assign full      = q_full;
	assign q_push    = accept;

	// window test and slot arithmetic, each sum stays below twice the depth where its slot is used
	always_comb begin
		ack_ofs   = item.ack_seq - oldest_q;
		hit       = ack_ofs < 32'(count_q);
		ring_full = count_q == DEPTH_C;
		step      = ack_ofs[CNT_W-1:0] + CNT_W'(1);
		wr_sum    = SUM_W'(head_q) + SUM_W'(count_q);
		rd_sum    = SUM_W'(head_q) + SUM_W'(ack_ofs[CNT_W-1:0]);
		nh_sum    = SUM_W'(head_q) + SUM_W'(step);
		wr_mod    = (wr_sum >= DEPTH_S) ? wr_sum - DEPTH_S : wr_sum;
		rd_mod    = (rd_sum >= DEPTH_S) ? rd_sum - DEPTH_S : rd_sum;
		nh_mod    = (nh_sum >= DEPTH_S) ? nh_sum - DEPTH_S : nh_sum;
	end

	// classify the item
	always_comb begin
		q_work.op     = iprt_pkg::OP_PASS;
		q_work.status = iprt_pkg::ST_DISABLED;
		q_work.seq    = '0;
		q_work.now_ms = item.now_ms;
		q_work.rts_ms = item.ack_receive_ts;
		q_slot        = wr_mod[IDX_W-1:0];
		if (enable_q) begin
			if (item.cmd == iprt_pkg::CMD_SEND) begin
				q_work.seq = next_seq_q;
				if (ring_full) begin
					q_work.status = iprt_pkg::ST_DROPPED;
				end else begin
					q_work.op     = iprt_pkg::OP_WRITE;
					q_work.status = iprt_pkg::ST_SENT;
				end
			end else begin
				q_work.seq = item.ack_seq;
				q_slot     = rd_mod[IDX_W-1:0];
				if (hit) begin
					q_work.op     = iprt_pkg::OP_READ;
					q_work.status = iprt_pkg::ST_MATCHED;
				end else begin
					q_work.status = iprt_pkg::ST_IGNORED;
				end
			end
		end
	end

	// enable register and ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b1;
			next_seq_q <= 32'd1;
			oldest_q   <= 32'd1;
			head_q     <= '0;
			count_q    <= '0;
		end else begin
			if (cfg_valid) begin
				enable_q <= cfg_data;
			end
			if (accept && enable_q) begin
				if (item.cmd == iprt_pkg::CMD_SEND) begin
					if (!ring_full) begin
						next_seq_q <= next_seq_q + 32'd1;
						count_q    <= count_q + CNT_W'(1);
					end
				end else if (hit) begin
					head_q   <= nh_mod[IDX_W-1:0];
					count_q  <= count_q - step;
					oldest_q <= oldest_q + 32'(step);
				end
			end
		end
	end

endmodule
`default_nettype wire

>>> hdl/iprt_fifo.sv
// two-entry queue between front and back
`default_nettype none
module iprt_fifo #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  empty
);

	logic [WIDTH-1:0] slots_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       fill_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = fill_q == 2'd2;
	assign empty   = fill_q == 2'd0;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = slots_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slots_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_wr, do_rd})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> hdl/iprt_back.sv
// back end: send-time table, rtt and one-way delay, result register
`default_nettype none
module iprt_back #(
	parameter int TABLE_DEPTH = 256
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 q_empty,
	input  wire iprt_pkg::work_t      q_work,
	input  wire logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] q_slot,
	output logic                      q_pop,
	output logic                      empty,
	input  wire logic                 pop,
	output iprt_pkg::result_t         result
);

	logic [31:0]       times_q [TABLE_DEPTH];
	logic [31:0]       rd_data_q;
	logic              rd_pend_q;
	logic [31:0]       rd_seq_q;
	logic [31:0]       rd_now_q;
	logic [31:0]       rd_rts_q;
	logic              out_valid_q;
	iprt_pkg::result_t out_q;

	logic out_free;
	logic do_wr;
	logic do_rd;

	assign out_free = !out_valid_q || pop;
	assign q_pop    = !q_empty && !rd_pend_q && out_free;
	assign do_wr    = q_pop && q_work.op == iprt_pkg::OP_WRITE;
	assign do_rd    = q_pop && q_work.op == iprt_pkg::OP_READ;
	assign empty    = !out_valid_q;
	assign result   = out_q;

	// send-time table with registered read
	always_ff @(posedge clk) begin
		if (do_wr) begin
			times_q[q_slot] <= q_work.now_ms;
		end
		if (do_rd) begin
			rd_data_q <= times_q[q_slot];
		end
	end

	// ack details held while the table read completes
	always_ff @(posedge clk) begin
		if (do_rd) begin
			rd_seq_q <= q_work.seq;
			rd_now_q <= q_work.now_ms;
			rd_rts_q <= q_work.rts_ms;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (rd_pend_q && out_free) begin
			out_q.status <= iprt_pkg::ST_MATCHED;
			out_q.seq    <= rd_seq_q;
			out_q.rtt_ms <= rd_now_q - rd_data_q;
			out_q.owd_ms <= rd_rts_q - rd_data_q;
		end else if (q_pop && !do_rd) begin
			out_q.status <= q_work.status;
			out_q.seq    <= q_work.seq;
			out_q.rtt_ms <= '0;
			out_q.owd_ms <= '0;
		end
	end

	// read pending and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_rd) begin
				rd_pend_q <= 1'b1;
			end else if (rd_pend_q && out_free) begin
				rd_pend_q <= 1'b0;
			end
			if ((rd_pend_q && out_free) || (q_pop && !do_rd)) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

>>> hdl/iprt_check.sv
// port-level checks of the tracker and their binding
`default_nettype none
module iprt_check (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              empty,
	input wire logic              pop,
	input wire iprt_pkg::result_t result
);

	// a waiting result beat holds until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result beat changed before pop");

	// the status of a waiting result is always a defined code
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> result.status <= iprt_pkg::ST_DISABLED)
		else $error("undefined result status");

	// only a matched ack carries timing
	a_timing: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.status != iprt_pkg::ST_MATCHED |->
		result.rtt_ms == 32'd0 && result.owd_ms == 32'd0)
		else $error("timing on an unmatched result");

	// a disabled item reports sequence zero
	a_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.status == iprt_pkg::ST_DISABLED |-> result.seq == 32'd0)
		else $error("disabled result with nonzero sequence");

endmodule

bind inflight_packet_rtt_tracker iprt_check u_check (.*);
`default_nettype wire

>>> bench/rtt_tracker_checker.sv
// scoreboard that predicts and checks every result beat of the rtt tracker
`timescale 1ns / 1ps
module rtt_tracker_checker #(
	parameter int DEPTH = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	input  wire logic              cfg_ready,
	input  wire logic              cfg_data,
	input  wire logic              push,
	input  wire logic              full,
	input  wire iprt_pkg::item_t   item,
	input  wire logic              empty,
	input  wire logic              pop,
	input  wire iprt_pkg::result_t result,
	output int                     errors,
	output int                     pending,
	output logic [31:0]            win_base,
	output int                     win_count
);
	import iprt_pkg::*;

	localparam int IW = $clog2(DEPTH);

	// predicted tracker state
	logic            enabled;
	logic [31:0]     next_seq;
	logic [31:0]     oldest;
	logic [IW-1:0]   head;
	logic [IW:0]     count;
	logic [31:0]     send_time_mem [DEPTH];
	result_t         expected_q [$];

	// apply one accepted item to the predicted state, return its result
	function automatic result_t track_item(input item_t it);
		result_t     r;
		logic [31:0] d;
		logic [31:0] t;
		r = '0;
		if (!enabled) begin
			r.status = ST_DISABLED;
		end else if (it.cmd == CMD_SEND) begin
			r.seq = next_seq;
			if (count >= DEPTH) begin
				r.status = ST_DROPPED;
			end else begin
				send_time_mem[(32'(head) + 32'(count)) % DEPTH] = it.now_ms;
				count = count + 1'b1;
				next_seq = next_seq + 32'd1;
				r.status = ST_SENT;
			end
		end else begin
			// wrap-safe window test, then cumulative retire
			d = it.ack_seq - oldest;
			r.seq = it.ack_seq;
			if (d >= 32'(count)) begin
				r.status = ST_IGNORED;
			end else begin
				t = send_time_mem[(32'(head) + d) % DEPTH];
				head = IW'((32'(head) + d + 32'd1) % DEPTH);
				count = count - (IW+1)'(d + 32'd1);
				oldest = oldest + d + 32'd1;
				r.status = ST_MATCHED;
				r.rtt_ms = it.now_ms - t;
				r.owd_ms = it.ack_receive_ts - t;
			end
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// watch config, input and result beats
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			enabled = 1'b1;
			next_seq = 32'd1;
			oldest = 32'd1;
			head = '0;
			count = '0;
			expected_q.delete();
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				enabled = cfg_data;
			// result beat against the oldest expectation
			if (pop && !empty) begin
				if (expected_q.size() == 0) begin
					$display("%0t: result beat with none expected, actual %h", $time, result);
					errors++;
				end else begin
					want = expected_q[0];
					expected_q.delete(0);
					check_field("status", 32'(want.status), 32'(result.status));
					check_field("seq", want.seq, result.seq);
					check_field("rtt_ms", want.rtt_ms, result.rtt_ms);
					check_field("owd_ms", want.owd_ms, result.owd_ms);
				end
			end
			// input beat
			if (push && !full)
				expected_q.push_back(track_item(item));
		end
		pending = expected_q.size();
		win_base = oldest;
		win_count = int'(count);
	end

endmodule

>>> bench/testbench.sv
// top of the rtt tracker bench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module testbench;
	import iprt_pkg::*;

	localparam int DEPTH = 256;
	localparam int LIMIT = 600000;

	typedef enum logic {
		MIX_NORMAL,
		MIX_FILL
	} mix_e;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_data;
	logic        push;
	logic        full;
	item_t       item;
	logic        empty;
	logic        pop = 1'b0;
	result_t     result;

	int          errors;
	int          pending;
	logic [31:0] win_base;
	int          win_count;
	int          cycles = 0;
	logic [31:0] cur_time;
	int          burst_left;
	int          pop_stall = 0;
	int          pop_greedy = 0;
	int          pop_roll;

	inflight_packet_rtt_tracker #(.TABLE_DEPTH(DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

	rtt_tracker_checker #(.DEPTH(DEPTH)) u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.errors    (errors),
		.pending   (pending),
		.win_base  (win_base),
		.win_count (win_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// result side: random stalls, some long, with greedy stretches
	always @(negedge clk) begin
		if (pop_greedy > 0) begin
			pop <= 1'b1;
			pop_greedy--;
		end else if (pop_stall > 0) begin
			pop <= 1'b0;
			pop_stall--;
		end else begin
			pop_roll = $urandom_range(0, 99);
			if (pop_roll < 3) begin
				pop_greedy = $urandom_range(50, 200);
				pop <= 1'b1;
			end else if (pop_roll < 8) begin
				pop_stall = $urandom_range(10, 40);
				pop <= 1'b0;
			end else if (pop_roll < 30) begin
				pop_stall = $urandom_range(0, 2);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	function automatic item_t make_item(input logic cmd, input logic [31:0] now,
			input logic [31:0] aseq, input logic [31:0] rts);
		item_t it;
		it.cmd = cmd;
		it.now_ms = now;
		it.ack_seq = aseq;
		it.ack_receive_ts = rts;
		return it;
	endfunction

	// hold one input beat until it is taken
	task automatic send_item(input item_t it);
		item <= it;
		push <= 1'b1;
		@(posedge clk);
		while (full)
			@(posedge clk);
		@(negedge clk);
	endtask

	// sender idle time between beats
	task automatic sender_gap();
		int roll;
		int n;
		n = 0;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		roll = $urandom_range(0, 99);
		if (roll < 6)
			burst_left = $urandom_range(40, 150);
		else if (roll < 60)
			n = 0;
		else if (roll < 92)
			n = $urandom_range(1, 3);
		else
			n = $urandom_range(5, 40);
		if (n > 0) begin
			push <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// stop sending until every result is back, then let the pipe drain
	task automatic settle();
		push <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_enable(input logic v);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly sends and in-window acks, the rest stale, early or random acks
	function automatic item_t next_random_item(input mix_e mix);
		item_t       it;
		int          roll;
		int          send_pct;
		int          ack_pct;
		logic [31:0] d;
		send_pct = (mix == MIX_FILL) ? 92 : 55;
		ack_pct = (mix == MIX_FILL) ? 4 : 40;
		if ($urandom_range(0, 99) < 3)
			cur_time = cur_time + $urandom();
		else
			cur_time = cur_time + $urandom_range(0, 20);
		it.now_ms = cur_time;
		it.ack_seq = $urandom();
		it.ack_receive_ts = $urandom();
		roll = $urandom_range(0, 99);
		if (roll < send_pct) begin
			it.cmd = CMD_SEND;
		end else begin
			it.cmd = CMD_ACK;
			if (roll < send_pct + ack_pct && win_count > 0) begin
				if (mix == MIX_FILL)
					d = 0;
				else if ($urandom_range(0, 1))
					d = $urandom_range(0, win_count - 1);
				else
					d = $urandom_range(0, (win_count > 4) ? 3 : win_count - 1);
				it.ack_seq = win_base + d;
				if ($urandom_range(0, 1))
					it.ack_receive_ts = cur_time - $urandom_range(0, 10);
			end else begin
				case ($urandom_range(0, 3))
					0: it.ack_seq = win_base - $urandom_range(1, 5);
					1: it.ack_seq = win_base + 32'(win_count) + $urandom_range(0, 3);
					2: it.ack_seq = win_base;
					default: ;
				endcase
			end
		end
		return it;
	endfunction

	task automatic run_phase(input mix_e mix, input int n, input logic [31:0] t0);
		item_t it;
		cur_time = t0;
		repeat (n) begin
			sender_gap();
			it = next_random_item(mix);
			send_item(it);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		burst_left = 0;
		cur_time = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		set_enable(1'b1);

		// directed: empty ring, time extremes, window edges, cumulative ack
		send_item(make_item(CMD_ACK, 32'd7, 32'd1, 32'd3));
		send_item(make_item(CMD_SEND, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_item(make_item(CMD_SEND, 32'hFFFF_FFFF, 32'h0, 32'h0));
		send_item(make_item(CMD_SEND, 32'd100, 32'h5555_5555, 32'hAAAA_AAAA));
		send_item(make_item(CMD_ACK, 32'd50, 32'd0, 32'd40));
		send_item(make_item(CMD_ACK, 32'd50, 32'd4, 32'd40));
		send_item(make_item(CMD_ACK, 32'd5, 32'd2, 32'hFFFF_FFFF));
		send_item(make_item(CMD_ACK, 32'd6, 32'd1, 32'd2));
		send_item(make_item(CMD_ACK, 32'hFFFF_FFFF, 32'd3, 32'd0));
		send_item(make_item(CMD_ACK, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_item(make_item(CMD_SEND, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555));
		send_item(make_item(CMD_SEND, 32'h8000_0000, 32'h0, 32'h0));
		send_item(make_item(CMD_ACK, 32'h0000_0010, 32'd4, 32'h0000_0008));
		send_item(make_item(CMD_ACK, 32'h8000_0001, 32'd5, 32'h7FFF_FFFF));

		// disabled: items ignored, state kept
		settle();
		set_enable(1'b0);
		send_item(make_item(CMD_SEND, 32'd1, 32'd2, 32'd3));
		send_item(make_item(CMD_ACK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		settle();
		set_enable(1'b1);
		send_item(make_item(CMD_SEND, 32'd200, 32'd0, 32'd0));
		send_item(make_item(CMD_ACK, 32'd210, 32'd6, 32'd205));

		// random phases
		settle();
		run_phase(MIX_NORMAL, 400, $urandom());
		settle();
		set_enable(1'b0);
		run_phase(MIX_NORMAL, 60, $urandom());
		settle();
		set_enable(1'b1);
		run_phase(MIX_FILL, 320, $urandom());
		settle();
		run_phase(MIX_NORMAL, 450, 32'hFFFF_FF00);

		// drain
		push <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

>>> filelist.f
hdl/iprt_pkg.sv
hdl/iprt_front.sv
hdl/iprt_fifo.sv
hdl/iprt_back.sv
hdl/inflight_packet_rtt_tracker.sv
hdl/iprt_check.sv
bench/rtt_tracker_checker.sv
bench/testbench.sv
